// ===== hw/rtl/rme_pkg.sv =====
// Shared types, codes and helpers for the rendezvous message engine.
// Used by the control memory, the message memory and the top level.
`timescale 1ns / 1ps

package rme_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam logic [1:0] OP_LIVE = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_RECV = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOSUCH   = 2'd1;
  localparam logic [1:0] STAT_DEADLOCK = 2'd2;

  localparam logic [1:0] SLOT_UNUSED    = 2'd0;
  localparam logic [1:0] SLOT_RUNNABLE  = 2'd1;
  localparam logic [1:0] SLOT_SENDING   = 2'd2;
  localparam logic [1:0] SLOT_RECEIVING = 2'd3;

  typedef struct packed {
    logic [1:0] state;
    logic [3:0] send_tgt;
    logic       wait_any;
    logic [3:0] wait_slot;
  } ctl_entry_t;

  typedef struct packed {
    logic signed [31:0] word2;
    logic signed [31:0] word1;
    logic signed [31:0] mtype;
  } msg_t;

  typedef struct packed {
    logic [1:0] status;
    logic       delivered;
    logic       blocked;
    logic [3:0] deliver_slot;
    logic [3:0] msg_source;
    msg_t       msg;
  } result_t;

  function automatic result_t res_plain(input logic [1:0] status, input logic blocked);
    result_t r;
    r = '0;
    r.status = status;
    r.blocked = blocked;
    return r;
  endfunction

endpackage

// ===== hw/rtl/rme_ctl_mem.sv =====
// Slot control memory: state, send link and wait source per slot.
// Valid bits make never-written entries read as unused. Depends on rme_pkg.
`timescale 1ns / 1ps

module rme_ctl_mem import rme_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_addr,
  output ctl_entry_t       rd_data,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_addr,
  input  ctl_entry_t       wr_data
);

  ctl_entry_t             mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  vld_r;
  ctl_entry_t             rd_ent_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) vld_r[wr_addr] <= 1'b1;
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_ent_r <= mem[rd_addr];
  end

  assign rd_data = rd_vld_r ? rd_ent_r : '0;

endmodule

// ===== hw/rtl/rme_msg_mem.sv =====
// Parked message memory: one type word and two payload words per slot.
// Contents are undefined until a send parks there. Depends on rme_pkg.
`timescale 1ns / 1ps

module rme_msg_mem import rme_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  output msg_t             rd_data,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_addr,
  input  msg_t             wr_data
);

  msg_t mem [SLOT_COUNT];
  msg_t rd_r;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  assign rd_data = rd_r;

endmodule

// ===== hw/rtl/rendezvous_message_engine.sv =====
// Rendezvous message engine: top level with the operation sequencer.
// Depends on rme_pkg, rme_ctl_mem and rme_msg_mem.
`timescale 1ns / 1ps

// One operation per input transfer, one result transfer per operation. The
// engine works on one operation at a time; per-slot state lives in a control
// memory and a message memory, both read in the cycle after the address
// is set. A send that parks first walks the deadlock chain, reading one
// control memory entry per hop. A receive from any sender scans the slots
// in order, one control read per slot. A new operation is taken while a
// finished result still waits in the output register. No clearing pass is
// needed after reset: per-slot valid bits make unwritten slots read unused.
module rendezvous_message_engine import rme_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [3:0] requester_slot, [7:4] target_slot, [8] target_any,
  // [40:9] msg_type, [72:41] msg_word1, [104:73] msg_word2, rest zero
  input  logic [111:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] delivered, [1] caller_blocked, [5:2] deliver_slot, [9:6] msg_source,
  // [41:10] out_type, [73:42] out_word1, [105:74] out_word2, rest zero
  output logic [111:0] out_tdata,
  // [1:0] status
  output logic [1:0]   out_tuser
);

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int STEP_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_TGT, S_WALK, S_RTGT, S_SCAN, S_FIN, S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [3:0]        req_r, req_nxt;
  logic [3:0]        tgt_r, tgt_nxt;
  logic              any_r, any_nxt;
  msg_t              msg_r, msg_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [IDX_W-1:0]  rd_addr_r, rd_addr_nxt;
  result_t           res_r, res_nxt;
  result_t           out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;

  ctl_entry_t        ent;
  msg_t              msg_rd;
  logic              ctl_we;
  logic [IDX_W-1:0]  ctl_wa;
  ctl_entry_t        ctl_wd;
  logic              msg_we;

  logic              in_fire;
  logic [1:0]        in_op;
  logic [3:0]        in_req, in_tgt;
  logic              in_any;
  msg_t              in_msg;
  logic              in_req_ok, in_tgt_ok;

  // Slot numbers are 4 bits; memory indexes are IDX_W bits.
  logic [IDX_W+3:0]  in_req_ext, in_tgt_ext, req_ext, bst_ext, addr_ext;
  logic [IDX_W-1:0]  in_req_idx, in_tgt_idx, req_idx, bst_idx;
  logic [3:0]        addr_slot;

  assign in_op  = in_tuser;
  assign in_req = in_tdata[3:0];
  assign in_tgt = in_tdata[7:4];
  assign in_any = in_tdata[8];
  assign in_msg.mtype = in_tdata[40:9];
  assign in_msg.word1 = in_tdata[72:41];
  assign in_msg.word2 = in_tdata[104:73];

  assign in_req_ok = 32'(in_req) < SLOT_COUNT;
  assign in_tgt_ok = 32'(in_tgt) < SLOT_COUNT;

  assign in_req_ext = {IDX_W'(0), in_req};
  assign in_tgt_ext = {IDX_W'(0), in_tgt};
  assign req_ext    = {IDX_W'(0), req_r};
  assign bst_ext    = {IDX_W'(0), ent.send_tgt};
  assign addr_ext   = {4'b0, rd_addr_r};
  assign in_req_idx = in_req_ext[IDX_W-1:0];
  assign in_tgt_idx = in_tgt_ext[IDX_W-1:0];
  assign req_idx    = req_ext[IDX_W-1:0];
  assign bst_idx    = bst_ext[IDX_W-1:0];
  assign addr_slot  = addr_ext[3:0];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  rme_ctl_mem #(.SLOT_COUNT(SLOT_COUNT), .IDX_W(IDX_W)) u_ctl_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr_nxt),
    .rd_data (ent),
    .we      (ctl_we),
    .wr_addr (ctl_wa),
    .wr_data (ctl_wd)
  );

  // Message reads follow the control read address so a parked message
  // arrives together with its sender's control entry.
  rme_msg_mem #(.SLOT_COUNT(SLOT_COUNT), .IDX_W(IDX_W)) u_msg_mem (
    .clk     (clk),
    .rd_addr (rd_addr_nxt),
    .rd_data (msg_rd),
    .we      (msg_we),
    .wr_addr (req_idx),
    .wr_data (msg_r)
  );

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    req_nxt     = req_r;
    tgt_nxt     = tgt_r;
    any_nxt     = any_r;
    msg_nxt     = msg_r;
    steps_nxt   = steps_r;
    rd_addr_nxt = rd_addr_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_tready;
    ctl_we      = 1'b0;
    ctl_wa      = rd_addr_r;
    ctl_wd      = '0;
    msg_we      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt  = in_op;
          req_nxt = in_req;
          tgt_nxt = in_tgt;
          any_nxt = in_any;
          msg_nxt = in_msg;
          state_nxt = S_RESP;
          res_nxt = res_plain(STAT_OK, 1'b0);
          if (in_op == OP_NOP) begin
            res_nxt = res_plain(STAT_OK, 1'b0);
          end else if (!in_req_ok) begin
            res_nxt = res_plain(STAT_NOSUCH, 1'b0);
          end else begin
            unique case (in_op)
              OP_LIVE: begin
                // Make live: runnable, links cleared.
                ctl_we = 1'b1;
                ctl_wa = in_req_idx;
                ctl_wd.state = SLOT_RUNNABLE;
              end
              OP_SEND: begin
                if (!in_tgt_ok) begin
                  res_nxt = res_plain(STAT_NOSUCH, 1'b0);
                end else begin
                  rd_addr_nxt = in_tgt_idx;
                  state_nxt = S_TGT;
                end
              end
              OP_RECV: begin
                if (in_any) begin
                  rd_addr_nxt = '0;
                  state_nxt = S_SCAN;
                end else if (!in_tgt_ok) begin
                  res_nxt = res_plain(STAT_NOSUCH, 1'b0);
                end else begin
                  rd_addr_nxt = in_tgt_idx;
                  state_nxt = S_RTGT;
                end
              end
              default: res_nxt = res_plain(STAT_OK, 1'b0);
            endcase
          end
        end
      end

      S_TGT: begin
        state_nxt = S_RESP;
        if (ent.state == SLOT_UNUSED) begin
          res_nxt = res_plain(STAT_NOSUCH, 1'b0);
        end else if (tgt_r == req_r) begin
          res_nxt = res_plain(STAT_DEADLOCK, 1'b0);
        end else if (ent.state == SLOT_RECEIVING && (ent.wait_any || ent.wait_slot == req_r)) begin
          // Direct hand-over: wake the receiver, clear its wait source.
          ctl_we = 1'b1;
          ctl_wd.state = SLOT_RUNNABLE;
          ctl_wd.send_tgt = ent.send_tgt;
          res_nxt = res_plain(STAT_OK, 1'b0);
          res_nxt.delivered = 1'b1;
          res_nxt.deliver_slot = tgt_r;
          res_nxt.msg_source = req_r;
          res_nxt.msg = msg_r;
        end else begin
          // Hold the read address: the walk starts on the target's entry.
          steps_nxt = '0;
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        if (ent.state == SLOT_SENDING) begin
          if (ent.send_tgt == req_r || 32'(steps_r) >= SLOT_COUNT) begin
            res_nxt = res_plain(STAT_DEADLOCK, 1'b0);
            state_nxt = S_RESP;
          end else if (32'(ent.send_tgt) >= SLOT_COUNT) begin
            rd_addr_nxt = req_idx;
            state_nxt = S_FIN;
          end else begin
            rd_addr_nxt = bst_idx;
            steps_nxt = steps_r + STEP_W'(1);
          end
        end else begin
          rd_addr_nxt = req_idx;
          state_nxt = S_FIN;
        end
      end

      S_RTGT: begin
        if (ent.state == SLOT_UNUSED) begin
          res_nxt = res_plain(STAT_NOSUCH, 1'b0);
          state_nxt = S_RESP;
        end else if (ent.state == SLOT_SENDING && ent.send_tgt == req_r) begin
          ctl_we = 1'b1;
          ctl_wd.state = SLOT_RUNNABLE;
          ctl_wd.wait_any = ent.wait_any;
          ctl_wd.wait_slot = ent.wait_slot;
          res_nxt = res_plain(STAT_OK, 1'b0);
          res_nxt.delivered = 1'b1;
          res_nxt.deliver_slot = req_r;
          res_nxt.msg_source = tgt_r;
          res_nxt.msg = msg_rd;
          state_nxt = S_RESP;
        end else begin
          rd_addr_nxt = req_idx;
          state_nxt = S_FIN;
        end
      end

      S_SCAN: begin
        if (ent.state == SLOT_SENDING && ent.send_tgt == req_r) begin
          // Lowest matching sender: wake it and take its parked message.
          ctl_we = 1'b1;
          ctl_wd.state = SLOT_RUNNABLE;
          ctl_wd.wait_any = ent.wait_any;
          ctl_wd.wait_slot = ent.wait_slot;
          res_nxt = res_plain(STAT_OK, 1'b0);
          res_nxt.delivered = 1'b1;
          res_nxt.deliver_slot = req_r;
          res_nxt.msg_source = addr_slot;
          res_nxt.msg = msg_rd;
          state_nxt = S_RESP;
        end else if (rd_addr_r == LAST_IDX) begin
          rd_addr_nxt = req_idx;
          state_nxt = S_FIN;
        end else begin
          rd_addr_nxt = rd_addr_r + IDX_W'(1);
        end
      end

      S_FIN: begin
        // Block the requester, keeping the link fields this operation leaves alone.
        ctl_we = 1'b1;
        ctl_wd = ent;
        if (op_r == OP_SEND) begin
          ctl_wd.state = SLOT_SENDING;
          ctl_wd.send_tgt = tgt_r;
          msg_we = 1'b1;
        end else begin
          ctl_wd.state = SLOT_RECEIVING;
          ctl_wd.wait_any = any_r;
          ctl_wd.wait_slot = tgt_r;
        end
        res_nxt = res_plain(STAT_OK, 1'b1);
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_nxt = res_r;
          out_vld_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      steps_r   <= '0;
      rd_addr_r <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      steps_r   <= steps_nxt;
      rd_addr_r <= rd_addr_nxt;
    end
    op_r  <= op_nxt;
    req_r <= req_nxt;
    tgt_r <= tgt_nxt;
    any_r <= any_nxt;
    msg_r <= msg_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {6'b0, out_r.msg.word2, out_r.msg.word1, out_r.msg.mtype,
                       out_r.msg_source, out_r.deliver_slot, out_r.blocked,
                       out_r.delivered};

  a_dlv_not_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_r.delivered && out_r.blocked))
    else $error("result both delivered and blocked");

  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_r.status != STAT_OK) |-> (!out_r.delivered && !out_r.blocked))
    else $error("error result carries delivery or block");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (32'(steps_r) <= SLOT_COUNT))
    else $error("deadlock walk exceeded its bound");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser != OP_LIVE) |-> !ctl_we)
    else $error("control write during accept of a non make-live operation");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for rendezvous_message_engine: predicts each result
// from a local slot model and checks every output transfer. Depends on rme_pkg.
`timescale 1ns / 1ps

module tb;
  import rme_pkg::*;

  localparam int NSLOT = 16;

  typedef struct {
    logic [1:0]  status;
    logic        delivered;
    logic        blocked;
    logic [3:0]  dslot;
    logic [3:0]  src;
    logic [31:0] mtype;
    logic [31:0] w1;
    logic [31:0] w2;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [1:0] out_tuser;

  rendezvous_message_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow slot table
  logic [1:0]  slot_st [NSLOT];
  logic [3:0]  send_to [NSLOT];
  logic        wait_all [NSLOT];
  logic [3:0]  wait_from [NSLOT];
  logic [31:0] park_t [NSLOT];
  logic [31:0] park_1 [NSLOT];
  logic [31:0] park_2 [NSLOT];

  outcome_t pending_outcomes[$];
  int mismatches = 0;
  int outcomes_seen = 0;
  int deliveries_seen = 0;
  int deadlocks_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  function automatic outcome_t plain(logic [1:0] st, logic blk);
    outcome_t o;
    o = '{default: '0};
    o.status = st;
    o.blocked = blk;
    return o;
  endfunction

  // Advance the shadow table by one operation and return the expected outcome.
  function automatic outcome_t rendezvous_step(logic [1:0] op, logic [3:0] req,
      logic [3:0] tgt, logic any, logic [31:0] mt, logic [31:0] m1, logic [31:0] m2);
    outcome_t o;
    logic [3:0] hop;
    int steps;
    o = '{default: '0};
    case (op)
      OP_NOP: begin
        return plain(STAT_OK, 1'b0);
      end
      OP_LIVE: begin
        slot_st[req] = SLOT_RUNNABLE;
        send_to[req] = '0;
        wait_all[req] = 1'b0;
        wait_from[req] = '0;
        return plain(STAT_OK, 1'b0);
      end
      OP_SEND: begin
        if (slot_st[tgt] == SLOT_UNUSED) return plain(STAT_NOSUCH, 1'b0);
        if (tgt == req) return plain(STAT_DEADLOCK, 1'b0);
        if (slot_st[tgt] == SLOT_RECEIVING && (wait_all[tgt] || wait_from[tgt] == req)) begin
          slot_st[tgt] = SLOT_RUNNABLE;
          wait_all[tgt] = 1'b0;
          wait_from[tgt] = '0;
          o.delivered = 1'b1;
          o.dslot = tgt;
          o.src = req;
          o.mtype = mt;
          o.w1 = m1;
          o.w2 = m2;
          return o;
        end
        // Walk the chain of blocked senders; a loop back to req is a deadlock.
        hop = tgt;
        steps = 0;
        while (slot_st[hop] == SLOT_SENDING) begin
          if (send_to[hop] == req || steps >= NSLOT) return plain(STAT_DEADLOCK, 1'b0);
          hop = send_to[hop];
          steps++;
        end
        slot_st[req] = SLOT_SENDING;
        send_to[req] = tgt;
        park_t[req] = mt;
        park_1[req] = m1;
        park_2[req] = m2;
        return plain(STAT_OK, 1'b1);
      end
      default: begin
        if (!any && slot_st[tgt] == SLOT_UNUSED) return plain(STAT_NOSUCH, 1'b0);
        for (int s = 0; s < NSLOT; s++) begin
          if (slot_st[s] == SLOT_SENDING && send_to[s] == req && (any || s == tgt)) begin
            slot_st[s] = SLOT_RUNNABLE;
            send_to[s] = '0;
            o.delivered = 1'b1;
            o.dslot = req;
            o.src = 4'(s);
            o.mtype = park_t[s];
            o.w1 = park_1[s];
            o.w2 = park_2[s];
            return o;
          end
        end
        slot_st[req] = SLOT_RECEIVING;
        wait_all[req] = any;
        wait_from[req] = any ? 4'd0 : tgt;
        return plain(STAT_OK, 1'b1);
      end
    endcase
  endfunction

  // Offer one operation and hold it until accepted; tvalid stays up for the
  // next operation and drops only when the sender idles or drains.
  task automatic send_op(logic [1:0] op, logic [3:0] req, logic [3:0] tgt,
      logic any, logic [31:0] mt, logic [31:0] m1, logic [31:0] m2);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'd0, m2, m1, mt, any, tgt, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_outcomes.push_back(rendezvous_step(op, req, tgt, any, mt, m1, m2));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5, 0))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random idling, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n || recv_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    outcome_t e;
    logic [111:0] a;
    if (rst_n && out_tvalid && out_tready) begin
      a = out_tdata;
      outcomes_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer data=%h", a);
      end else begin
        e = pending_outcomes.pop_front();
        if (e.delivered) deliveries_seen++;
        if (e.status == STAT_DEADLOCK) deadlocks_seen++;
        if (out_tuser != e.status || a[0] != e.delivered || a[1] != e.blocked ||
            a[5:2] != e.dslot || a[9:6] != e.src || a[41:10] != e.mtype ||
            a[73:42] != e.w1 || a[105:74] != e.w2 || a[111:106] != '0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp st=%0d dlv=%0b blk=%0b slot=%0d src=%0d %h %h %h",
                     e.status, e.delivered, e.blocked, e.dslot, e.src, e.mtype, e.w1, e.w2);
            $display("          got st=%0d data=%h", out_tuser, a);
          end
        end
      end
    end
  end

  // Directed: edges of fields, all ops, error cases, delivery both ways, deadlock.
  task automatic test_directed();
    send_op(OP_NOP, 4'd15, 4'd15, 1'b1, '1, '1, '1);
    send_op(OP_SEND, 4'd0, 4'd15, 1'b0, 0, 0, 0);          // unused target
    send_op(OP_RECV, 4'd3, 4'd9, 1'b0, 0, 0, 0);           // unused source
    send_op(OP_RECV, 4'd3, 4'd0, 1'b1, 0, 0, 0);           // any, unused caller blocks
    send_op(OP_LIVE, 4'd0, 4'd0, 1'b0, 0, 0, 0);
    send_op(OP_LIVE, 4'd15, 4'd0, 1'b0, 0, 0, 0);
    send_op(OP_LIVE, 4'd3, 4'd0, 1'b0, 0, 0, 0);
    send_op(OP_SEND, 4'd15, 4'd15, 1'b0, 1, 2, 3);         // self send
    send_op(OP_RECV, 4'd0, 4'd15, 1'b0, 0, 0, 0);          // 0 waits on 15
    send_op(OP_SEND, 4'd15, 4'd0, 1'b0, 32'h8000_0000, 32'h7fff_ffff, '1);
    send_op(OP_SEND, 4'd0, 4'd15, 1'b0, '1, 32'h8000_0000, 32'h7fff_ffff); // 0 parks
    send_op(OP_SEND, 4'd15, 4'd3, 1'b0, 5, 6, 7);          // 15 parks on 3
    send_op(OP_SEND, 4'd3, 4'd0, 1'b0, 8, 9, 10);          // cycle -> deadlock
    send_op(OP_RECV, 4'd3, 4'd0, 1'b1, 0, 0, 0);           // takes 15
    send_op(OP_RECV, 4'd15, 4'd0, 1'b0, 0, 0, 0);          // takes 0
    send_op(OP_RECV, 4'd15, 4'd3, 1'b0, 0, 0, 0);          // blocks on 3
    send_op(OP_SEND, 4'd3, 4'd15, 1'b0, 11, 12, 13);       // delivers
    drain();
  endtask

  task automatic random_ops(int n);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      // Keep slots mostly small so chains and matches form often.
      case ($urandom_range(9, 0))
        0, 1: op = OP_LIVE;
        2, 3, 4, 5: op = OP_SEND;
        9: op = OP_NOP;
        default: op = OP_RECV;
      endcase
      send_op(op, ($urandom_range(3, 0) == 0) ? 4'($urandom()) : 4'($urandom_range(5, 0)),
              ($urandom_range(3, 0) == 0) ? 4'($urandom()) : 4'($urandom_range(5, 0)),
              1'($urandom()), rand_word(), rand_word(), rand_word());
    end
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 21; recv_idle_pct = 59;
    random_ops(210);
    drain();
  endtask

  task automatic test_random_receiver_idle();
    send_idle_pct = 59; recv_idle_pct = 21;
    random_ops(210);
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; recv_idle_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (200) @(posedge clk);
        recv_hold = 1'b0;
      end
      random_ops(40);
    join
    drain();
  endtask

  task automatic test_random_full_rate();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_ops(190);
    drain();
  endtask

  initial begin
    for (int s = 0; s < NSLOT; s++) begin
      slot_st[s] = SLOT_UNUSED; send_to[s] = '0; wait_all[s] = 1'b0; wait_from[s] = '0;
      park_t[s] = '0; park_1[s] = '0; park_2[s] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_sender_idle();
    test_random_receiver_idle();
    test_backpressure();
    test_random_full_rate();
    $display("covered %0d results: %0d deliveries, %0d deadlock or self-send refusals",
             outcomes_seen, deliveries_seen, deadlocks_seen);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("** rendezvous_message_engine: PASSED **");
    end else begin
      $display("** rendezvous_message_engine: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout, %0d results outstanding", pending_outcomes.size());
    $display("** rendezvous_message_engine: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rme_pkg.sv
hw/rtl/rme_ctl_mem.sv
hw/rtl/rme_msg_mem.sv
hw/rtl/rendezvous_message_engine.sv
bench/tb.sv
